[rtl/core/sspg_pkg.sv]
// ----------------------------------------------------------------------------
// sspg_pkg
// Shared types and constants of the stepper step-pulse generator.
// ----------------------------------------------------------------------------
package sspg_pkg;

    // fixed point layout of increment and accumulator (Q16.24)
    localparam int FRAC_BITS    = 24;
    localparam int ACC_WIDTH    = 40;
    localparam int HI_W         = ACC_WIDTH - FRAC_BITS;

    localparam int SPEED_W      = 16;
    localparam int MAG_W        = 15;
    localparam int TICK_W       = 16;
    localparam int PROD_W       = MAG_W + TICK_W;
    localparam int DIV_STEPS    = PROD_W + FRAC_BITS;
    localparam int STEP_CNT_W   = $clog2(DIV_STEPS);

    localparam int US_PER_S_INT = 1000000;
    localparam int REM_W        = $clog2(US_PER_S_INT);
    localparam logic [REM_W:0] US_PER_S = (REM_W + 1)'(US_PER_S_INT);

    // accumulator is added one digit per cycle
    localparam int DIGIT_W      = 8;
    localparam int ACC_DIGITS   = ACC_WIDTH / DIGIT_W;
    localparam int DIGIT_CNT_W  = $clog2(ACC_DIGITS);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [MAG_W-1:0]  MAX_SPEED_RST = 15'd32767;
    localparam logic [TICK_W-1:0] TICK_US_RST   = 16'd100;
    localparam logic [MAG_W-1:0]  RAMP_STEP_RST = 15'd200;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SET    = 2'd1,
        MODE_TARGET = 2'd2,
        MODE_RAMP   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_TICK_US   = 2'd1,
        CFG_INVERT    = 2'd2,
        CFG_RAMP_STEP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [SPEED_W-1:0] speed_value;
    } t_in_item;

    typedef struct packed {
        logic                      step_pulse;
        logic                      direction_level;
        logic signed [SPEED_W-1:0] current_speed;
    } t_out_item;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_APPLY,
        ST_INCR,
        ST_ADD,
        ST_FIN,
        ST_OUT
    } t_state;

    // increment unit sequencer
    typedef enum logic [1:0] {
        IS_IDLE,
        IS_MUL,
        IS_DIV,
        IS_DONE
    } t_incr_state;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [TICK_W-1:0] tick_us;
    } t_incr_req;

    typedef struct packed {
        logic                 done;
        logic [ACC_WIDTH-1:0] inc;
    } t_incr_rsp;

endpackage

[rtl/core/sspg_incr.sv]
// ----------------------------------------------------------------------------
// sspg_incr
// Per-tick increment: mag * tick_us * 2^FRAC_BITS / 1e6, bit-serial
// shift-add multiply followed by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module sspg_incr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sspg_pkg::t_incr_req i_req,
    output sspg_pkg::t_incr_rsp o_rsp
);
    import sspg_pkg::*;

    t_incr_state             r_state, n_state;
    logic [STEP_CNT_W-1:0]   r_cnt, n_cnt;
    logic [MAG_W-1:0]        r_mplier, n_mplier;
    logic [TICK_W-1:0]       r_tick, n_tick;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [ACC_WIDTH-1:0]    r_quo, n_quo;
    logic                    r_ovf, n_ovf;

    logic [REM_W:0]          trial;
    logic                    ge;
    logic                    mul_last, div_last;

    assign mul_last = (r_cnt == STEP_CNT_W'(MAG_W - 1));
    assign div_last = (r_cnt == STEP_CNT_W'(DIV_STEPS - 1));
    assign trial    = {r_rem, r_prod[PROD_W-1]};
    assign ge       = (trial >= US_PER_S);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            IS_IDLE: if (i_req.start) n_state = IS_MUL;
            IS_MUL:  if (mul_last) n_state = IS_DIV;
            IS_DIV:  if (div_last) n_state = IS_DONE;
            IS_DONE: n_state = IS_IDLE;
            default: n_state = IS_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_mplier = r_mplier;
        n_tick   = r_tick;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_ovf    = r_ovf;
        o_rsp.done = 1'b0;
        o_rsp.inc  = r_ovf ? '1 : r_quo;
        unique case (r_state)
            IS_IDLE: begin
                if (i_req.start) begin
                    n_cnt    = '0;
                    n_mplier = i_req.mag;
                    n_tick   = i_req.tick_us;
                    n_prod   = '0;
                    n_rem    = '0;
                    n_quo    = '0;
                    n_ovf    = 1'b0;
                end
            end
            IS_MUL: begin
                // MSB first: shift, then add the multiplicand
                n_prod   = {r_prod[PROD_W-2:0], 1'b0}
                         + (r_mplier[MAG_W-1] ? PROD_W'(r_tick) : '0);
                n_mplier = {r_mplier[MAG_W-2:0], 1'b0};
                n_cnt    = mul_last ? '0 : r_cnt + 1'b1;
            end
            IS_DIV: begin
                // zeros shift in behind the product: the fraction bits
                n_prod = {r_prod[PROD_W-2:0], 1'b0};
                n_rem  = ge ? REM_W'(trial - US_PER_S) : REM_W'(trial);
                n_quo  = {r_quo[ACC_WIDTH-2:0], ge};
                n_ovf  = r_ovf | r_quo[ACC_WIDTH-1];
                n_cnt  = r_cnt + 1'b1;
            end
            IS_DONE: o_rsp.done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_mplier <= n_mplier;
        r_tick   <= n_tick;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_ovf    <= n_ovf;
    end

endmodule

[rtl/core/stepper_step_pulse_generator.sv]
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator
// Step-pulse generator with speed ramp and fractional phase accumulator.
// ----------------------------------------------------------------------------
// Input channel (valid/ready) carries one beat per item: mode and a signed
// speed. Each item gives exactly one output beat with the step pulse, the
// direction level and the stored current speed.
// Items are handled one at a time; o_in_ready is high only while idle.
// Steps from input beat to output valid:
//   tick            the 40-bit accumulator add in 5 digits, saturate/step,
//                   output load
//   set target      output load only
//   set speed       apply, then the increment unit: a serial multiply and
//                   a serial divide by one million, one bit per cycle;
//                   ramp adds a ramp step before apply
// The output register lets the next input beat be taken while a result still
// waits; a stalled receiver holds the block in its output state once the next
// result is ready. Configuration is written via i_cfg_we/i_cfg_idx/i_cfg_data
// by the user only while idle; the block does not enforce it. Synchronous
// reset clears speeds, increment, acc., direction; loads 32767, 100, 0, 200.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sspg_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sspg_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [sspg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sspg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sspg_pkg::*;

    t_state                    r_state, n_state;
    logic [DIGIT_CNT_W-1:0]    r_cnt, n_cnt;
    logic                      r_carry, n_carry;
    logic [ACC_WIDTH-1:0]      r_acc, n_acc;
    logic [ACC_WIDTH-1:0]      r_inc, n_inc;
    logic signed [SPEED_W-1:0] r_now, n_now;
    logic signed [SPEED_W-1:0] r_target, n_target;
    logic signed [SPEED_W-1:0] r_speed_new, n_speed_new;
    logic                      r_dir, n_dir;
    logic                      r_pulse, n_pulse;
    logic                      r_o_valid, n_o_valid;
    t_out_item                 r_out, n_out;

    logic [MAG_W-1:0]          r_max_speed;
    logic [TICK_W-1:0]         r_tick_us;
    logic                      r_invert;
    logic [MAG_W-1:0]          r_ramp_step;

    t_incr_req                 incr_req;
    t_incr_rsp                 incr_rsp;

    logic                      in_acc;
    logic                      out_free;
    logic                      add_last;
    logic [DIGIT_W:0]          dsum;
    logic [ACC_WIDTH-1:0]      sat_acc;
    logic [HI_W-1:0]           hi;
    logic signed [SPEED_W:0]   diff;
    logic [SPEED_W:0]          diff_mag;
    logic [SPEED_W:0]          ramp_mag;
    logic signed [SPEED_W:0]   ramp_speed;
    logic [SPEED_W:0]          abs_new;
    logic [MAG_W-1:0]          clamp_mag;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_o_valid || i_out_ready;
    assign add_last    = (r_cnt == DIGIT_CNT_W'(ACC_DIGITS - 1));
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    // digit adder
    assign dsum = {1'b0, r_acc[DIGIT_W-1:0]} + {1'b0, r_inc[DIGIT_W-1:0]}
                + {{DIGIT_W{1'b0}}, r_carry};

    // saturate, then take one step when at least 1.0 is stored
    assign sat_acc = r_carry ? '1 : r_acc;
    assign hi      = sat_acc[ACC_WIDTH-1:FRAC_BITS];

    // ramp toward target by at most ramp_step
    assign diff       = {r_target[SPEED_W-1], r_target} - {r_now[SPEED_W-1], r_now};
    assign diff_mag   = diff[SPEED_W] ? (SPEED_W + 1)'(-diff) : diff;
    assign ramp_mag   = (diff_mag > (SPEED_W + 1)'(r_ramp_step))
                      ? (SPEED_W + 1)'(r_ramp_step) : diff_mag;
    assign ramp_speed = diff[SPEED_W]
                      ? {r_now[SPEED_W-1], r_now} - signed'(ramp_mag)
                      : {r_now[SPEED_W-1], r_now} + signed'(ramp_mag);

    // magnitude clamped to max_speed
    assign abs_new   = r_speed_new[SPEED_W-1]
                     ? (SPEED_W + 1)'(-{r_speed_new[SPEED_W-1], r_speed_new})
                     : {1'b0, r_speed_new};
    assign clamp_mag = (abs_new > (SPEED_W + 1)'(r_max_speed))
                     ? r_max_speed : abs_new[MAG_W-1:0];

    assign incr_req.start   = (r_state == ST_APPLY);
    assign incr_req.mag     = clamp_mag;
    assign incr_req.tick_us = r_tick_us;

    sspg_incr u_incr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (incr_req),
        .o_rsp   (incr_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_mode'(i_in_data.mode))
                        MODE_TICK:   n_state = ST_ADD;
                        MODE_SET:    n_state = ST_APPLY;
                        MODE_TARGET: n_state = ST_OUT;
                        MODE_RAMP:   n_state = ST_RAMP;
                        default:     n_state = ST_OUT;
                    endcase
                end
            end
            ST_RAMP:  n_state = ST_APPLY;
            ST_APPLY: n_state = ST_INCR;
            ST_INCR:  if (incr_rsp.done) n_state = ST_OUT;
            ST_ADD:   if (add_last) n_state = ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_carry     = r_carry;
        n_acc       = r_acc;
        n_inc       = r_inc;
        n_now       = r_now;
        n_target    = r_target;
        n_speed_new = r_speed_new;
        n_dir       = r_dir;
        n_pulse     = r_pulse;
        n_out       = r_out;
        n_o_valid   = r_o_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cnt       = '0;
                    n_carry     = 1'b0;
                    n_pulse     = 1'b0;
                    n_speed_new = i_in_data.speed_value;
                    if (t_mode'(i_in_data.mode) == MODE_TARGET) begin
                        n_target = i_in_data.speed_value;
                    end
                end
            end
            ST_RAMP:  n_speed_new = SPEED_W'(ramp_speed);
            ST_APPLY: begin
                n_now = r_speed_new;
                n_dir = (!r_speed_new[SPEED_W-1]) == r_invert;
            end
            ST_INCR:  if (incr_rsp.done) n_inc = incr_rsp.inc;
            ST_ADD: begin
                // rotate both words one digit so they land back in place
                n_acc   = {dsum[DIGIT_W-1:0], r_acc[ACC_WIDTH-1:DIGIT_W]};
                n_inc   = {r_inc[DIGIT_W-1:0], r_inc[ACC_WIDTH-1:DIGIT_W]};
                n_carry = dsum[DIGIT_W];
                n_cnt   = r_cnt + 1'b1;
            end
            ST_FIN: begin
                n_pulse = |hi;
                n_acc   = {hi - HI_W'(|hi), sat_acc[FRAC_BITS-1:0]};
            end
            ST_OUT: begin
                if (out_free) begin
                    n_o_valid             = 1'b1;
                    n_out.step_pulse      = r_pulse;
                    n_out.direction_level = r_dir;
                    n_out.current_speed   = r_now;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
            r_inc     <= '0;
            r_now     <= '0;
            r_target  <= '0;
            r_dir     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_acc     <= n_acc;
            r_inc     <= n_inc;
            r_now     <= n_now;
            r_target  <= n_target;
            r_dir     <= n_dir;
        end
        r_cnt       <= n_cnt;
        r_carry     <= n_carry;
        r_speed_new <= n_speed_new;
        r_pulse     <= n_pulse;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
            r_tick_us   <= TICK_US_RST;
            r_invert    <= 1'b0;
            r_ramp_step <= RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[MAG_W-1:0];
                CFG_TICK_US:   r_tick_us   <= i_cfg_data[TICK_W-1:0];
                CFG_INVERT:    r_invert    <= i_cfg_data[0];
                CFG_RAMP_STEP: r_ramp_step <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/sspg_checker.sv]
// ----------------------------------------------------------------------------
// sspg_checker
// Port-level checks of the step-pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module sspg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sspg_pkg::t_out_item o_out_data
);
    import sspg_pkg::*;

    // one item at a time: busy right after an input beat
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // a new result appears only out of a busy cycle
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result beat without an item in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output beat changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind stepper_step_pulse_generator sspg_checker u_sspg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
